>>> rtl/rbl_pkg.sv
// Package: constants and types shared by the red band locator files.
`default_nettype none

package rbl_pkg;

    localparam int MAX_WIDTH   = 160;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int CFG_W       = 8;
    localparam int CHAN_W      = 8;
    localparam int POS_W       = 9;
    localparam int VOTE_W      = 3;
    localparam int ROW_W       = 3;
    localparam int RED_CNT_W   = 8;
    localparam int BAND_ROWS   = 5;
    localparam int VOTE_MIN    = 3;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(BAND_ROWS - 1);
    localparam logic signed [POS_W-1:0] NO_COL = -POS_W'(1);

    typedef logic [COL_W-1:0]        col_t;
    typedef logic [CFG_W-1:0]        cfg_word_t;
    typedef logic [CHAN_W-1:0]       chan_t;
    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic [VOTE_W-1:0]       vote_t;
    typedef logic [ROW_W-1:0]        row_t;
    typedef logic [RED_CNT_W-1:0]    red_cnt_t;

    // Per-pixel control carried from the address stage to the update stage
    typedef struct packed {
        logic first_row;
        logic last_row;
        logic emit;
        logic clear;
        logic red;
        col_t col;
    } pix_ctl_t;

endpackage

`default_nettype wire

>>> rtl/rbl_if.sv
// Interfaces: pixel, result and configuration channels.
`default_nettype none

interface rbl_pixel_if;
    logic                 valid;
    logic                 ready;
    logic                 band_start;
    rbl_pkg::chan_t       chan_a;
    rbl_pkg::chan_t       chan_b;
    rbl_pkg::chan_t       red_level;

    modport source (output valid, band_start, chan_a, chan_b, red_level, input ready);
    modport sink   (input valid, band_start, chan_a, chan_b, red_level, output ready);
endinterface

interface rbl_result_if;
    logic                 valid;
    logic                 ready;
    rbl_pkg::pos_t        first_col;
    rbl_pkg::pos_t        last_col;
    rbl_pkg::pos_t        center_col;
    logic                 red_present;

    modport source (output valid, first_col, last_col, center_col, red_present,
                    input ready);
    modport sink   (input valid, first_col, last_col, center_col, red_present,
                    output ready);
endinterface

interface rbl_cfg_if;
    logic                 valid;
    logic                 ready;
    rbl_pkg::cfg_word_t   data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

>>> rtl/red_band_locator_top.sv
// Top level: red band locator with column vote memory and result register.
//
//  channel | dir | payload                                        | accepted when
//  --------+-----+------------------------------------------------+-------------------
//  cfg     | in  | data = width_in_use                            | valid & ready
//  pix     | in  | band_start, chan_a, chan_b, red_level          | valid & ready
//  res     | out | first_col, last_col, center_col, red_present   | valid & ready
//
// One pixel per clock while pix.ready is high. A pixel reads its column vote in the address
// stage and writes it back in the update stage; a write to the column read in the same cycle
// is forwarded. res.valid rises once the last pixel of row five leaves the update stage.
// pix.ready drops only while a band-end pixel waits for the result register.
// rst_n clears all control; the vote memory is not cleared (row one overwrites).
`default_nettype none

module red_band_locator_top (
    input  wire logic     clk,
    input  wire logic     rst_n,
    rbl_cfg_if.sink       cfg,
    rbl_pixel_if.sink     pix,
    rbl_result_if.source  res
);
    import rbl_pkg::*;

    // Configuration
    cfg_word_t width_reg;
    cfg_word_t eff_w;

    // Address stage state
    row_t      row_reg, row_next;
    col_t      col_reg, col_next;

    // Update stage
    logic      s1_valid_reg;
    pix_ctl_t  s1_ctl_reg, s0_ctl;
    vote_t     rdata_reg;
    logic      fwd_reg;
    vote_t     fwd_val_reg;
    logic      s1_stall;
    logic      s1_adv;
    logic      accept;

    pos_t      first_reg, last_reg;
    red_cnt_t  redcnt_reg;

    // Result register
    logic      out_valid_reg;
    pos_t      out_first_reg, out_last_reg, out_center_reg;
    logic      out_present_reg;

    vote_t     votes_mem [MAX_WIDTH];

    // Address stage combinational signals
    col_t            cur_col, col;
    row_t            cur_row;
    logic            row_end;
    logic [CHAN_W:0] ab_sum;

    // Update stage combinational signals
    vote_t             base_vote;
    logic [VOTE_W:0]   total;
    logic              col_red;
    pos_t              first_base, last_base, first_upd, last_upd;
    red_cnt_t          redcnt_base, redcnt_upd;
    logic signed [POS_W:0] mid_sum;
    logic [RED_CNT_W+2:0]  redcnt_x5;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= CFG_W'(MAX_WIDTH);
        end
        else if (cfg.valid && cfg.ready)
        begin
            width_reg <= cfg.data;
        end
    end

    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = CFG_W'(1);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            eff_w = CFG_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = width_reg;
        end
    end

    // Handshake: stall only when a band-end pixel finds the result register busy
    assign s1_stall  = s1_valid_reg && s1_ctl_reg.emit && out_valid_reg && !res.ready;
    assign s1_adv    = s1_valid_reg && !s1_stall;
    assign pix.ready = !s1_stall;
    assign accept    = pix.valid && pix.ready;

    // Address stage
    always_comb
    begin
        cur_col = pix.band_start ? '0 : col_reg;
        cur_row = pix.band_start ? '0 : row_reg;
        if (16'(cur_col) >= 16'(eff_w))
        begin
            col = COL_W'(eff_w - CFG_W'(1));
        end
        else
        begin
            col = cur_col;
        end
        row_end = (16'(col) + 16'd1) >= 16'(eff_w);
        ab_sum  = {1'b0, pix.chan_a} + {1'b0, pix.chan_b};

        s0_ctl.first_row = (cur_row == '0);
        s0_ctl.last_row  = (cur_row >= LAST_ROW);
        s0_ctl.emit      = row_end && (cur_row >= LAST_ROW);
        s0_ctl.clear     = pix.band_start;
        s0_ctl.red       = ({1'b0, pix.red_level} > ab_sum);
        s0_ctl.col       = col;

        if (row_end)
        begin
            col_next = '0;
            row_next = (cur_row >= LAST_ROW) ? '0 : cur_row + ROW_W'(1);
        end
        else
        begin
            col_next = col + COL_W'(1);
            row_next = cur_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
                // forward the vote being written this edge to the same column
                fwd_reg <= s1_adv && (s1_ctl_reg.col == col);
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctl_reg  <= s0_ctl;
            fwd_val_reg <= total[VOTE_W-1:0];
        end
    end

    // Vote memory: read in the address stage, write back in the update stage
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            votes_mem[s1_ctl_reg.col] <= total[VOTE_W-1:0];
        end
        if (accept)
        begin
            rdata_reg <= votes_mem[col];
        end
    end

    // Update stage
    always_comb
    begin
        if (s1_ctl_reg.first_row)
        begin
            base_vote = '0;
        end
        else if (fwd_reg)
        begin
            base_vote = fwd_val_reg;
        end
        else
        begin
            base_vote = rdata_reg;
        end
        total   = {1'b0, base_vote} + {{VOTE_W{1'b0}}, s1_ctl_reg.red};
        col_red = s1_ctl_reg.last_row && (total >= (VOTE_W + 1)'(VOTE_MIN));

        first_base  = s1_ctl_reg.clear ? NO_COL : first_reg;
        last_base   = s1_ctl_reg.clear ? NO_COL : last_reg;
        redcnt_base = s1_ctl_reg.clear ? '0 : redcnt_reg;

        first_upd  = first_base;
        last_upd   = last_base;
        redcnt_upd = redcnt_base;
        if (col_red)
        begin
            if (first_base < 0)
            begin
                first_upd = POS_W'(s1_ctl_reg.col);
            end
            last_upd   = POS_W'(s1_ctl_reg.col);
            redcnt_upd = redcnt_base + RED_CNT_W'(1);
        end

        mid_sum   = (POS_W + 1)'(first_upd) + (POS_W + 1)'(last_upd);
        redcnt_x5 = (RED_CNT_W + 3)'(redcnt_upd) + ((RED_CNT_W + 3)'(redcnt_upd) << 2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= NO_COL;
            last_reg   <= NO_COL;
            redcnt_reg <= '0;
        end
        else if (s1_adv)
        begin
            if (s1_ctl_reg.emit)
            begin
                first_reg  <= NO_COL;
                last_reg   <= NO_COL;
                redcnt_reg <= '0;
            end
            else
            begin
                first_reg  <= first_upd;
                last_reg   <= last_upd;
                redcnt_reg <= redcnt_upd;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_ctl_reg.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_ctl_reg.emit)
        begin
            out_first_reg   <= first_upd;
            out_last_reg    <= last_upd;
            out_center_reg  <= (first_upd < 0) ? NO_COL : POS_W'(mid_sum >>> 1);
            out_present_reg <= (redcnt_x5 >= (RED_CNT_W + 3)'(eff_w));
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.first_col   = out_first_reg;
    assign res.last_col    = out_last_reg;
    assign res.center_col  = out_center_reg;
    assign res.red_present = out_present_reg;

`ifndef SYNTH
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= LAST_ROW)
        else $error("row index past last band row");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_adv && s1_ctl_reg.emit))
        else $error("result raised without a band-end pixel");

    a_fwd_source: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s1_adv && (s1_ctl_reg.col == col)) |=> fwd_reg)
        else $error("vote write-back not forwarded to same column");

    a_first_last: assert property (@(posedge clk) disable iff (!rst_n)
        (first_reg >= 0) |-> (last_reg >= first_reg))
        else $error("last red column left of first");
`endif

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Testbench: checks the red band locator against a behavioral prediction of its band results.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rbl_pkg::*;

    typedef struct {
        pos_t first_col;
        pos_t last_col;
        pos_t center_col;
        logic red_present;
    } band_result_t;

    logic clk = 1'b0;
    logic rst_n;

    rbl_cfg_if    cfg_ch ();
    rbl_pixel_if  pix_ch ();
    rbl_result_if res_ch ();

    red_band_locator_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .pix   (pix_ch),
        .res   (res_ch)
    );

    always #2 clk = ~clk;

    // Predicted block state
    vote_t        col_votes [MAX_WIDTH];
    row_t         cur_row;
    int           cur_col;
    int           first_hit;
    int           last_hit;
    int           red_cols;
    cfg_word_t    width_reg;

    band_result_t expected_bands [$];
    band_result_t want;
    int           errors;
    int           pixels_sent;
    bit           quiet_tail;

    function automatic int active_width(input int w);
        if (w == 0)
            return 1;
        if (w > MAX_WIDTH)
            return MAX_WIDTH;
        return w;
    endfunction

    function automatic void restart_band();
        cur_row   = '0;
        cur_col   = 0;
        first_hit = -1;
        last_hit  = -1;
        red_cols  = 0;
    endfunction

    // Advance the predicted state by one accepted pixel; queue a result at band end
    function automatic void absorb_pixel(input logic bs, input chan_t a, input chan_t b,
                                         input chan_t r);
        int           w;
        int           c;
        int           total;
        int           is_red;
        band_result_t br;
        w = active_width(width_reg);
        if (bs)
            restart_band();
        c = (cur_col >= w) ? w - 1 : cur_col;
        is_red = (int'(r) > int'(a) + int'(b)) ? 1 : 0;
        total = (cur_row == 0) ? is_red : int'(col_votes[c]) + is_red;
        col_votes[c] = vote_t'(total);
        if (cur_row >= LAST_ROW && total >= VOTE_MIN)
        begin
            if (first_hit < 0)
                first_hit = c;
            last_hit = c;
            red_cols = (red_cols + 1) & 8'hFF;
        end
        if (c + 1 < w)
        begin
            cur_col = c + 1;
            return;
        end
        cur_col = 0;
        if (cur_row < LAST_ROW)
        begin
            cur_row = cur_row + 1'b1;
            return;
        end
        br.first_col   = pos_t'(first_hit);
        br.last_col    = pos_t'(last_hit);
        br.center_col  = (first_hit < 0) ? NO_COL : pos_t'((first_hit + last_hit) / 2);
        br.red_present = (red_cols * 5 >= w);
        expected_bands.push_back(br);
        restart_band();
    endfunction

    // Pick pixel bytes; pct < 0 gives raw random bytes, else the chance of a red pixel
    function automatic void shade(input int pct, output chan_t a, output chan_t b,
                                  output chan_t r);
        int sa;
        int sb;
        if (pct < 0)
        begin
            a = chan_t'($urandom);
            b = chan_t'($urandom);
            r = chan_t'($urandom);
        end
        else if ($urandom_range(0, 99) < pct)
        begin
            sa = $urandom_range(0, 127);
            sb = $urandom_range(0, 127);
            a  = chan_t'(sa);
            b  = chan_t'(sb);
            r  = chan_t'($urandom_range(sa + sb + 1, 255));
        end
        else
        begin
            sa = $urandom_range(0, 255);
            sb = $urandom_range(0, 255);
            a  = chan_t'(sa);
            b  = chan_t'(sb);
            r  = chan_t'($urandom_range(0, (sa + sb > 255) ? 255 : sa + sb));
        end
    endfunction

    task automatic send_pixel(input logic bs, input chan_t a, input chan_t b, input chan_t r);
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        pix_ch.valid      <= 1'b1;
        pix_ch.band_start <= bs;
        pix_ch.chan_a     <= a;
        pix_ch.chan_b     <= b;
        pix_ch.red_level  <= r;
        @(posedge clk);
        while (!(pix_ch.valid && pix_ch.ready))
            @(posedge clk);
        absorb_pixel(bs, a, b, r);
        pixels_sent++;
    endtask

    // Write the width register once the block has drained
    task automatic set_width(input cfg_word_t w);
        pix_ch.valid <= 1'b0;
        while (expected_bands.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_ch.data  <= w;
        cfg_ch.valid <= 1'b1;
        @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready))
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        width_reg = w;
    endtask

    task automatic test_width_extremes();
        chan_t a;
        chan_t b;
        chan_t r;
        int    k;
        // Width zero acts as one column: each row is a single pixel
        set_width(8'd0);
        send_pixel(1'b1, 8'd0,   8'd0,   8'd0);
        send_pixel(1'b0, 8'd0,   8'd0,   8'd1);
        send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
        send_pixel(1'b0, 8'd127, 8'd127, 8'd255);
        send_pixel(1'b0, 8'd128, 8'd127, 8'd255);
        // Next band starts on its own after the result
        for (k = 0; k < 5; k++)
        begin
            shade(100, a, b, r);
            send_pixel(1'b0, a, b, r);
        end
    endtask

    task automatic test_column_past_width();
        chan_t a;
        chan_t b;
        chan_t r;
        int    k;
        set_width(8'd160);
        for (k = 0; k < 2; k++)
        begin
            shade(100, a, b, r);
            send_pixel(k == 0, a, b, r);
        end
        // Shrink the row under the column pointer; the next pixel closes row one
        set_width(8'd2);
        for (k = 0; k < 9; k++)
        begin
            shade(100, a, b, r);
            send_pixel(1'b0, a, b, r);
        end
    endtask

    task automatic run_band(input int eff);
        int    col_pct [MAX_WIDTH];
        int    k;
        int    n;
        bit    noisy;
        bit    cut;
        chan_t a;
        chan_t b;
        chan_t r;
        noisy = ($urandom_range(0, 5) == 0);
        cut   = ($urandom_range(0, 7) == 0);
        for (k = 0; k < eff; k++)
            col_pct[k] = noisy ? -1 : 25 * $urandom_range(0, 4);
        // Abandon a band part way through with a fresh band_start
        if (cut)
        begin
            n = (eff == 1) ? $urandom_range(1, 4) : $urandom_range(1, 5 * eff - 1);
            for (k = 0; k < n; k++)
            begin
                shade(col_pct[k % eff], a, b, r);
                send_pixel(k == 0, a, b, r);
            end
        end
        for (k = 0; k < 5 * eff; k++)
        begin
            shade(col_pct[k % eff], a, b, r);
            send_pixel((k == 0) ? (cut || $urandom_range(0, 3) != 0) : 1'b0, a, b, r);
        end
    endtask

    task automatic test_random_bands();
        int w;
        int nb;
        // One full-size band with the register above its range
        set_width(8'hFF);
        run_band(MAX_WIDTH);
        do
        begin
            if (pixels_sent >= 1050)
                quiet_tail = 1'b1;
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            set_width(cfg_word_t'(w));
            nb = $urandom_range(1, 4);
            repeat (nb) run_band(active_width(w));
        end
        while (pixels_sent < 1300);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_bands.size() == 0)
            begin
                $display("%0t: unexpected result first=%0d last=%0d center=%0d present=%0b",
                         $time, res_ch.first_col, res_ch.last_col, res_ch.center_col,
                         res_ch.red_present);
                errors++;
            end
            else
            begin
                want = expected_bands.pop_front();
                if (res_ch.first_col !== want.first_col)
                begin
                    $display("%0t: first_col expected %0d actual %0d",
                             $time, want.first_col, res_ch.first_col);
                    errors++;
                end
                if (res_ch.last_col !== want.last_col)
                begin
                    $display("%0t: last_col expected %0d actual %0d",
                             $time, want.last_col, res_ch.last_col);
                    errors++;
                end
                if (res_ch.center_col !== want.center_col)
                begin
                    $display("%0t: center_col expected %0d actual %0d",
                             $time, want.center_col, res_ch.center_col);
                    errors++;
                end
                if (res_ch.red_present !== want.red_present)
                begin
                    $display("%0t: red_present expected %0b actual %0b",
                             $time, want.red_present, res_ch.red_present);
                    errors++;
                end
            end
        end
    end

    // Result side: random stall bursts, none in the tail of the run
    initial
    begin
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!quiet_tail && $urandom_range(0, 4) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        errors        = 0;
        pixels_sent   = 0;
        quiet_tail    = 1'b0;
        width_reg     = 8'd160;
        for (int k = 0; k < MAX_WIDTH; k++)
            col_votes[k] = '0;
        restart_band();
        rst_n             <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.data       <= '0;
        pix_ch.valid      <= 1'b0;
        pix_ch.band_start <= 1'b0;
        pix_ch.chan_a     <= '0;
        pix_ch.chan_b     <= '0;
        pix_ch.red_level  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_width_extremes();
        test_column_past_width();
        test_random_bands();

        pix_ch.valid <= 1'b0;
        while (expected_bands.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
